// File: rtl/core/psv_pkg.sv
// ----------------------------------------------------------------------------
// psv_pkg
// Types, codes and constants shared by the plucked string voice.
// ----------------------------------------------------------------------------
package psv_pkg;

  // default sizing of the voice
  localparam int BUFFER_DEPTH_DEF = 8192;
  localparam int SAMPLE_BITS_DEF  = 16;

  // configuration port
  localparam int APB_AW = 4;
  localparam int APB_DW = 32;

  localparam logic [1:0] REG_DAMPER    = 2'd0;
  localparam logic [1:0] REG_DEF_VOL   = 2'd1;
  localparam logic [1:0] REG_RMS_DECAY = 2'd2;
  localparam logic [1:0] REG_SIL_THR   = 2'd3;

  localparam logic [7:0]  DAMPER_RST    = 8'd18;
  localparam logic [7:0]  DEF_VOL_RST   = 8'd128;
  localparam logic [15:0] RMS_DECAY_RST = 16'd64763;
  localparam logic [31:0] SIL_THR_RST   = 32'd4096;

  // request codes
  localparam logic [2:0] REQ_SAMPLE  = 3'd0;
  localparam logic [2:0] REQ_PLUCK   = 3'd1;
  localparam logic [2:0] REQ_SLIDE   = 3'd2;
  localparam logic [2:0] REQ_RELEASE = 3'd3;
  localparam logic [2:0] REQ_SET_VOL = 3'd4;
  localparam logic [2:0] REQ_LEVEL   = 3'd5;
  localparam logic [2:0] REQ_STOP    = 3'd6;

  // noise generator
  localparam logic [31:0] LCG_MUL   = 32'd1103515245;
  localparam logic [31:0] LCG_ADD   = 32'd12345;
  localparam logic [31:0] SEED_INIT = 32'h16BA2118;

  localparam logic [15:0] AMP_RST   = 16'd32768;
  localparam int          LEN_RST   = 100;
  localparam int          OUT_LIMIT = 65024;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SWB,
    ST_FILL,
    ST_LVL,
    ST_DRAIN,
    ST_PUT
  } psv_state_t;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [13:0] period;
    logic [7:0]  volume;
  } in_item_t;

  typedef struct packed {
    logic signed [16:0] sample_out;
    logic               playing;
    logic [31:0]        level;
  } out_item_t;

endpackage

// File: rtl/core/plucked_string_voice_top.sv
// ----------------------------------------------------------------------------
// plucked_string_voice_top
// One plucked string voice: delay line in a RAM, damped feedback, noise pluck
// and a mean-square level check that silences the voice.
// ----------------------------------------------------------------------------
//  channel  direction  handshake               payload
//  in_      in         in_valid / in_stall     in_data  (in_item_t)
//  out_     out        out_valid / out_stall   out_data (out_item_t)
//  apb      in         psel/penable/pwrite     paddr, pwdata, prdata
//
//  sample request while playing: ram read, write-back, then output load
//  pluck: noise fill, one ram write per entry; other requests go straight to output load
//  level check: one ram read per entry into a 3-stage pipe
//  reset clears control state only; the delay line needs a pluck before use
//  a stalled output holds the finished transaction in the output register;
//  the next request is still taken and waits for the register to free up
// ----------------------------------------------------------------------------
module plucked_string_voice_top
  import psv_pkg::*;
#(
  parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF,
  parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_item_t          in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output out_item_t         out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  localparam int SB  = SAMPLE_BITS;
  localparam int AW  = $clog2(BUFFER_DEPTH);
  localparam int LW  = $clog2(BUFFER_DEPTH + 1);
  localparam int CW  = (LW > 14) ? LW : 14;
  localparam int LEN_INIT = (LEN_RST > BUFFER_DEPTH) ? BUFFER_DEPTH : LEN_RST;

  localparam int SQ_SH = 34 - 2 * SB;
  localparam int SQ_L  = (SQ_SH > 0) ? SQ_SH : 0;
  localparam int SQ_R  = (SQ_SH < 0) ? -SQ_SH : 0;
  localparam int SQW   = 2 * SB + SQ_L;

  localparam logic signed [SB+18:0] FB_MAX = (SB+19)'((64'sd1 <<< (SB - 1)) - 64'sd1);
  localparam logic signed [SB+18:0] FB_MIN = (SB+19)'(-(64'sd1 <<< (SB - 1)));
  localparam logic signed [SB+16:0] OL_HI  = (SB+17)'(OUT_LIMIT);
  localparam logic signed [SB+16:0] OL_LO  = (SB+17)'(-OUT_LIMIT);

  // control and voice state
  psv_state_t          state_r, state_nxt;
  logic [AW-1:0]       read_idx_r, read_idx_nxt;
  logic [LW-1:0]       len_r, len_nxt;
  logic signed [SB-1:0] prev_r, prev_nxt;
  logic [15:0]         amp_r, amp_nxt;
  logic                voice_r, voice_nxt;
  logic [31:0]         level_r, level_nxt;
  logic [31:0]         seed_r, seed_nxt;
  logic [AW-1:0]       cnt_r, cnt_nxt;
  logic signed [16:0]  res_r, res_nxt;
  logic                out_valid_r, out_valid_nxt;
  out_item_t           out_data_r, out_data_nxt;

  // configuration
  logic [7:0]  df_r;
  logic [7:0]  defvol_r;
  logic [15:0] decay_r;
  logic [31:0] thr_r;
  logic [16:0] g_r;
  logic [16:0] c1_r;
  logic [15:0] df_sq;
  logic        cfg_wr;

  // level pipeline
  logic        rd_v_r, rd_last_r;
  logic [32:0] sq_r;
  logic        sq_v_r, sq_last_r;
  logic [49:0] p1_r;
  logic        p_v_r, p_last_r;

  // memory port
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [SB-1:0] ram_wdata, ram_rdata;

  // datapath
  logic [CW-1:0]          per_w;
  logic [LW-1:0]          len_clamp;
  logic [LW-1:0]          idx_inc;
  logic                   cnt_last;
  logic signed [SB-1:0]   v;
  logic signed [SB:0]     fb_sum;
  logic signed [SB+18:0]  fb_p, fb_sh;
  logic [SB-1:0]          fb_sat;
  logic signed [SB+16:0]  o_p, o_sh;
  logic signed [16:0]     o_sat;
  logic [31:0]            lcg;
  logic signed [2*SB-1:0] vsq_s;
  logic [32:0]            sq_c;
  logic [49:0]            p1_c;
  logic [50:0]            qsum;
  logic [34:0]            qsh;
  logic [31:0]            qsat;

  psv_ram #(
    .WIDTH (SB),
    .DEPTH (BUFFER_DEPTH)
  ) u_line (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign df_sq  = pwdata[7:0] * pwdata[7:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      df_r     <= DAMPER_RST;
      defvol_r <= DEF_VOL_RST;
      decay_r  <= RMS_DECAY_RST;
      thr_r    <= SIL_THR_RST;
      g_r      <= 17'h10000 - 17'(DAMPER_RST) * 17'(DAMPER_RST);
      c1_r     <= 17'h10000 - {1'b0, RMS_DECAY_RST};
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_DAMPER: begin
          df_r <= pwdata[7:0];
          g_r  <= 17'h10000 - {1'b0, df_sq};
        end
        REG_DEF_VOL: begin
          defvol_r <= pwdata[7:0];
        end
        REG_RMS_DECAY: begin
          decay_r <= pwdata[15:0];
          c1_r    <= 17'h10000 - {1'b0, pwdata[15:0]};
        end
        REG_SIL_THR: begin
          thr_r <= pwdata;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_DAMPER:    prdata = {24'd0, df_r};
      REG_DEF_VOL:   prdata = {24'd0, defvol_r};
      REG_RMS_DECAY: prdata = {16'd0, decay_r};
      REG_SIL_THR:   prdata = thr_r;
      default:       prdata = '0;
    endcase
  end

  // period clamp, index wrap
  always_comb begin
    per_w = CW'(in_data.period);
    if (per_w < CW'(2)) begin
      len_clamp = LW'(2);
    end else if (per_w > CW'(BUFFER_DEPTH)) begin
      len_clamp = LW'(BUFFER_DEPTH);
    end else begin
      len_clamp = LW'(per_w);
    end
  end

  assign idx_inc  = LW'(read_idx_r) + LW'(1);
  assign cnt_last = (LW'(cnt_r) == len_r - LW'(1));

  // sample path: damped feedback and scaled output
  assign v      = signed'(ram_rdata);
  assign fb_sum = {v[SB-1], v} + {prev_r[SB-1], prev_r};
  assign fb_p   = fb_sum * signed'({1'b0, g_r});
  assign fb_sh  = fb_p >>> 17;
  assign fb_sat = (fb_sh > FB_MAX) ? SB'(FB_MAX) :
                  (fb_sh < FB_MIN) ? SB'(FB_MIN) : SB'(fb_sh);
  assign o_p    = v * signed'({1'b0, amp_r});
  assign o_sh   = o_p >>> (SB - 1);
  assign o_sat  = (o_sh > OL_HI) ? 17'(OL_HI) :
                  (o_sh < OL_LO) ? 17'(OL_LO) : 17'(o_sh);

  assign lcg = seed_r * LCG_MUL + LCG_ADD;

  // level path: square, weight, one-pole update
  assign vsq_s = v * v;
  assign sq_c  = 33'((SQW'(unsigned'(vsq_s)) << SQ_L) >> SQ_R);
  assign p1_c  = 50'(c1_r) * 50'(sq_r);
  assign qsum  = 51'(p1_r) + 51'(decay_r) * 51'(level_r);
  assign qsh   = qsum[50:16];
  assign qsat  = (qsh > 35'hFFFFFFFF) ? 32'hFFFFFFFF : qsh[31:0];

  always_comb begin
    state_nxt     = state_r;
    read_idx_nxt  = read_idx_r;
    len_nxt       = len_r;
    prev_nxt      = prev_r;
    amp_nxt       = amp_r;
    voice_nxt     = voice_r;
    level_nxt     = level_r;
    seed_nxt      = seed_r;
    cnt_nxt       = cnt_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    ram_we        = 1'b0;
    ram_waddr     = read_idx_r;
    ram_wdata     = fb_sat;
    ram_re        = 1'b0;
    ram_raddr     = read_idx_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          res_nxt   = '0;
          state_nxt = ST_PUT;
          unique case (in_data.req_type)
            REQ_SAMPLE: begin
              if (voice_r) begin
                ram_re    = 1'b1;
                state_nxt = ST_SWB;
              end
            end
            REQ_PLUCK, REQ_SLIDE: begin
              len_nxt      = len_clamp;
              read_idx_nxt = '0;
              prev_nxt     = '0;
              amp_nxt      = {defvol_r, 8'h00};
              voice_nxt    = 1'b1;
              level_nxt    = 32'hFFFFFFFF;
              cnt_nxt      = '0;
              if (in_data.req_type == REQ_PLUCK) begin
                state_nxt = ST_FILL;
              end
            end
            REQ_RELEASE: begin
              amp_nxt = amp_r >> 1;
            end
            REQ_SET_VOL: begin
              amp_nxt = {in_data.volume, 8'h00};
            end
            REQ_LEVEL: begin
              cnt_nxt = '0;
              if (voice_r) begin
                state_nxt = ST_LVL;
              end
            end
            REQ_STOP: begin
              voice_nxt = 1'b0;
              level_nxt = '0;
            end
            default: begin
            end
          endcase
        end
      end
      ST_SWB: begin
        // entry read last cycle: write back the damped average in place
        ram_we       = 1'b1;
        prev_nxt     = v;
        read_idx_nxt = (idx_inc >= len_r) ? '0 : AW'(idx_inc);
        res_nxt      = o_sat;
        state_nxt    = ST_PUT;
      end
      ST_FILL: begin
        seed_nxt  = lcg;
        ram_we    = 1'b1;
        ram_waddr = cnt_r;
        ram_wdata = lcg[31 -: SB];
        cnt_nxt   = cnt_r + AW'(1);
        if (cnt_last) begin
          prev_nxt  = signed'(lcg[31 -: SB]);
          state_nxt = ST_PUT;
        end
      end
      ST_LVL: begin
        ram_re    = 1'b1;
        ram_raddr = cnt_r;
        cnt_nxt   = cnt_r + AW'(1);
        if (cnt_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
      end
      ST_PUT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt           = 1'b1;
          out_data_nxt.sample_out = res_r;
          out_data_nxt.playing    = voice_r;
          out_data_nxt.level      = level_r;
          state_nxt               = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // filter step at the end of the level pipe
    if (p_v_r) begin
      level_nxt = qsat;
      if (p_last_r) begin
        state_nxt = ST_PUT;
        if (qsat < thr_r) begin
          level_nxt = '0;
          voice_nxt = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      read_idx_r  <= '0;
      len_r       <= LW'(LEN_INIT);
      prev_r      <= '0;
      amp_r       <= AMP_RST;
      voice_r     <= 1'b0;
      level_r     <= '0;
      seed_r      <= SEED_INIT;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      rd_v_r      <= 1'b0;
      rd_last_r   <= 1'b0;
      sq_v_r      <= 1'b0;
      sq_last_r   <= 1'b0;
      p_v_r       <= 1'b0;
      p_last_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      read_idx_r  <= read_idx_nxt;
      len_r       <= len_nxt;
      prev_r      <= prev_nxt;
      amp_r       <= amp_nxt;
      voice_r     <= voice_nxt;
      level_r     <= level_nxt;
      seed_r      <= seed_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      rd_v_r      <= (state_r == ST_LVL);
      rd_last_r   <= (state_r == ST_LVL) && cnt_last;
      sq_v_r      <= rd_v_r;
      sq_last_r   <= rd_last_r;
      p_v_r       <= sq_v_r;
      p_last_r    <= sq_last_r;
    end
  end

  always_ff @(posedge clk) begin
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
    sq_r       <= sq_c;
    p1_r       <= p1_c;
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // only write-back and fill write the delay line
  a_we_state: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == ST_SWB || state_r == ST_FILL))
    else $error("delay line written outside write-back or fill");

  // the last squared entry closes the level check
  a_lvl_end: assert property (@(posedge clk) disable iff (!rst_n)
    p_last_r |=> (state_r == ST_PUT))
    else $error("level check did not finish on its last entry");

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    (LW'(read_idx_r) < len_r) && (len_r >= LW'(2)) && (len_r <= LW'(BUFFER_DEPTH)))
    else $error("read index or line length out of range");

  a_out_from_put: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_PUT))
    else $error("output loaded outside the output state");

endmodule

// File: rtl/core/psv_ram.sv
// ----------------------------------------------------------------------------
// psv_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module psv_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
